FILE: rtl/ptrs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptrs_pkg
// Shared types and codes for the periodic task release scheduler.
// ----------------------------------------------------------------------------
package ptrs_pkg;

  typedef enum logic [2:0] {
    KIND_TIMER   = 3'd0,
    KIND_CREATE  = 3'd1,
    KIND_SUSPEND = 3'd2,
    KIND_RESUME  = 3'd3,
    KIND_DELETE  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_KILLED = 2'd0,
    ST_READY  = 2'd1,
    ST_PAUSED = 2'd2
  } status_t;

  // Work handed from the front end to the back end
  typedef struct packed {
    logic        is_tick;
    logic [2:0]  kind;
    logic [3:0]  task_index;
    logic [15:0] period;
    logic [7:0]  start_offset;
    logic [31:0] tick;
  } op_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DIV,
    BK_EMIT
  } bk_state_t;

  localparam int unsigned OutLimit = 8;

endpackage : ptrs_pkg
`default_nettype wire

FILE: rtl/ptrs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptrs_front
// Accepts operations, divides timer events into ticks, counts ticks and
// queues ticks and table edits for the back end.
// ----------------------------------------------------------------------------
module ptrs_front
  import ptrs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_kind,
  input  wire logic [3:0]  in_task_index,
  input  wire logic [15:0] in_period,
  input  wire logic [7:0]  in_start_offset,
  output logic             q_valid,
  input  wire logic        q_pop,
  output op_t              q_data
);

  localparam int unsigned Depth = 2;

  logic [15:0] divide_r, divide_nxt;
  logic [15:0] dcount_r, dcount_nxt;
  logic [31:0] tick_r, tick_nxt;
  op_t         fifo_r [Depth];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        push, take, tick_now;
  op_t         op;

  assign in_stall = (cnt_r == 2'(Depth));
  assign take     = in_valid && !in_stall;
  assign tick_now = (in_kind == KIND_TIMER) && (dcount_r <= 16'd1);

  // Classify and build the queued operation
  always_comb begin
    op.is_tick      = tick_now;
    op.kind         = in_kind;
    op.task_index   = in_task_index;
    op.period       = in_period;
    op.start_offset = in_start_offset;
    op.tick         = tick_r + 32'd1;
  end
  assign push = take && (in_kind != KIND_TIMER || tick_now);

  // Divider and tick counter
  always_comb begin
    divide_nxt = divide_r;
    dcount_nxt = dcount_r;
    tick_nxt   = tick_r;
    if (cfg_we) begin
      divide_nxt = cfg_wdata;
      dcount_nxt = cfg_wdata;
    end else if (take && in_kind == KIND_TIMER) begin
      if (dcount_r > 16'd1) begin
        dcount_nxt = dcount_r - 16'd1;
      end else begin
        dcount_nxt = divide_r;
        tick_nxt   = tick_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divide_r <= 16'd1;
      dcount_r <= 16'd1;
      tick_r   <= '0;
      wp_r     <= 1'b0;
      rp_r     <= 1'b0;
      cnt_r    <= '0;
    end else begin
      divide_r <= divide_nxt;
      dcount_r <= dcount_nxt;
      tick_r   <= tick_nxt;
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) fifo_r[wp_r] <= op;
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_data  = fifo_r[rp_r];

endmodule : ptrs_front
`default_nettype wire

FILE: rtl/ptrs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptrs_back
// Holds the task table, applies edits and scans it on every tick with a
// bit-serial modulo unit shared by all entries.
// ----------------------------------------------------------------------------
module ptrs_back
  import ptrs_pkg::*;
#(
  parameter int unsigned NUM_TASKS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  output logic             q_pop,
  input  op_t              q_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_due_task,
  output logic             out_last_due,
  output logic [31:0]      out_tick_number
);

  localparam int unsigned IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  logic [NUM_TASKS-1:0] valid_r;
  status_t              status_r [NUM_TASKS];
  logic [15:0]          period_r [NUM_TASKS];
  logic [7:0]           offset_r [NUM_TASKS];

  bk_state_t   state_r, state_nxt;
  logic [4:0]  idx_r;
  logic [IW-1:0] idx;
  logic [31:0] tick_r;
  logic [31:0] num_r;
  logic [15:0] rem_r;
  logic [5:0]  bit_r;
  logic [3:0]  cnt_r;
  logic        hit_pend_r;
  logic [3:0]  pend_idx_r;
  logic        ov_r;
  logic        eligible, scan_done;
  logic [16:0] rem_sh;
  logic [16:0] rem_sub;
  logic [15:0] rem_step;

  assign idx = idx_r[IW-1:0];
  assign eligible = valid_r[idx] && status_r[idx] == ST_READY &&
                    tick_r >= {24'd0, offset_r[idx]};
  assign scan_done = (idx_r == 5'(NUM_TASKS)) || (cnt_r == 4'(OutLimit));
  assign rem_sh = {rem_r, num_r[31]};
  assign rem_sub = rem_sh - {1'b0, period_r[idx]};
  assign rem_step = (rem_sh >= {1'b0, period_r[idx]}) ? rem_sub[15:0] : rem_sh[15:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (q_valid && q_data.is_tick) state_nxt = BK_SCAN;
      BK_SCAN: if (!ov_r || !out_stall) begin
        if (scan_done) state_nxt = BK_EMIT;
        else if (eligible) state_nxt = BK_DIV;
      end
      BK_DIV:  if (bit_r == 6'd31) state_nxt = BK_SCAN;
      BK_EMIT: if (!ov_r || !out_stall) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Outputs to the queue
  always_comb begin
    q_pop = 1'b0;
    case (state_r)
      BK_IDLE: q_pop = q_valid;
      default: q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_IDLE;
      valid_r    <= '0;
      ov_r       <= 1'b0;
      hit_pend_r <= 1'b0;
      for (int i = 0; i < NUM_TASKS; i++) status_r[i] <= ST_KILLED;
    end else begin
      state_r <= state_nxt;
      if (ov_r && !out_stall) ov_r <= 1'b0;
      case (state_r)
        BK_IDLE: begin
          idx_r      <= '0;
          cnt_r      <= '0;
          hit_pend_r <= 1'b0;
          tick_r     <= q_data.tick;
          // Apply table edits
          if (q_valid && !q_data.is_tick &&
              {1'b0, q_data.task_index} < 5'(NUM_TASKS)) begin
            case (q_data.kind)
              KIND_CREATE: if (q_data.period != 16'd0) begin
                valid_r[q_data.task_index[IW-1:0]]  <= 1'b1;
                status_r[q_data.task_index[IW-1:0]] <= ST_READY;
                period_r[q_data.task_index[IW-1:0]] <= q_data.period;
                offset_r[q_data.task_index[IW-1:0]] <= q_data.start_offset;
              end
              KIND_SUSPEND: status_r[q_data.task_index[IW-1:0]] <= ST_PAUSED;
              KIND_RESUME:
                if (status_r[q_data.task_index[IW-1:0]] == ST_PAUSED)
                  status_r[q_data.task_index[IW-1:0]] <= ST_READY;
              KIND_DELETE: begin
                status_r[q_data.task_index[IW-1:0]] <= ST_KILLED;
                valid_r[q_data.task_index[IW-1:0]]  <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        BK_SCAN: if (!ov_r || !out_stall) begin
          if (!scan_done) begin
            if (eligible) begin
              num_r <= tick_r - {24'd0, offset_r[idx]};
              rem_r <= '0;
              bit_r <= '0;
            end else begin
              idx_r <= idx_r + 5'd1;
            end
          end
        end
        BK_DIV: begin
          // One restoring step of the modulo per cycle
          num_r <= {num_r[30:0], 1'b0};
          bit_r <= bit_r + 6'd1;
          rem_r <= rem_step;
          if (bit_r == 6'd31) begin
            if (rem_step == 16'd0) begin
              // Flush any held hit, hold this one back to learn last_due
              if (hit_pend_r) begin
                ov_r            <= 1'b1;
                out_due_task    <= pend_idx_r;
                out_last_due    <= 1'b0;
                out_tick_number <= tick_r;
              end
              hit_pend_r <= 1'b1;
              pend_idx_r <= 4'(idx_r);
              cnt_r      <= cnt_r + 4'd1;
            end
            idx_r <= idx_r + 5'd1;
          end
        end
        BK_EMIT: if (!ov_r || !out_stall) begin
          if (hit_pend_r) begin
            ov_r            <= 1'b1;
            out_due_task    <= pend_idx_r;
            out_last_due    <= 1'b1;
            out_tick_number <= tick_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = ov_r;

endmodule : ptrs_back
`default_nettype wire

FILE: rtl/periodic_task_release_scheduler_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_task_release_scheduler_unit
// Periodic task table with divided timer ticks and release scan.
// ----------------------------------------------------------------------------
// Usage: operations enter on in_* (valid/stall); releases leave on out_*
// with out_last_due marking the final release of a tick. The user must write
// tick_divide through cfg_we/cfg_wdata only while the block is idle; the
// block itself does not enforce this. A tick is popped in the idle state,
// then the entries are scanned in order until all are seen or OutLimit
// releases are found: an entry that is not valid, ready and past its offset
// is skipped, each other entry is tested in the one-bit-per-cycle modulo
// unit, and the held final release is given at the end of the scan. A
// two-entry queue parts the front end from the scanning back end, so
// operations are taken while a scan runs until the queue fills.
// Reset (synchronous, rst_n low) clears the table, the tick counter and
// sets the divider to 1. When out_stall is high a held result stays and the
// scan waits until it is taken.
// ----------------------------------------------------------------------------
module periodic_task_release_scheduler_unit
  import ptrs_pkg::*;
#(
  parameter int unsigned NUM_TASKS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_kind,
  input  wire logic [3:0]  in_task_index,
  input  wire logic [15:0] in_period,
  input  wire logic [7:0]  in_start_offset,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_due_task,
  output logic             out_last_due,
  output logic [31:0]      out_tick_number
);

  logic q_valid, q_pop;
  op_t  q_data;

  ptrs_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_wdata,
    .in_valid, .in_stall, .in_kind, .in_task_index, .in_period, .in_start_offset,
    .q_valid, .q_pop, .q_data
  );

  ptrs_back #(.NUM_TASKS(NUM_TASKS)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_data,
    .out_valid, .out_stall, .out_due_task, .out_last_due, .out_tick_number
  );

endmodule : periodic_task_release_scheduler_unit
`default_nettype wire

FILE: dv/tb_periodic_task_release_scheduler_unit.sv
// ----------------------------------------------------------------------------
// tb_periodic_task_release_scheduler_unit
// Self-checking bench for the periodic task release scheduler: directed and
// random table edits and timer events under several tick dividers, with a
// scoreboard that mirrors the task table and checks every release in order.
// ----------------------------------------------------------------------------
module tb_periodic_task_release_scheduler_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import ptrs_pkg::*;

  localparam int unsigned NumSlots  = 8;
  localparam int unsigned DrainWait = 1000;
  localparam int unsigned IdleLimit = 20000;

  typedef struct {
    logic [3:0]  slot;
    logic        last;
    logic [31:0] tick;
  } release_t;

  // Task table mirror and queue of releases still owed by the block
  class release_scoreboard;
    logic [15:0] divide_reg;
    logic [15:0] divide_left;
    logic [31:0] ticks;
    logic        slot_valid [NumSlots];
    status_t     slot_status[NumSlots];
    logic [15:0] slot_period[NumSlots];
    logic [7:0]  slot_offset[NumSlots];
    release_t    owed[$];
    int          errors;
    int          releases_seen;
    int          ticks_done;

    function new();
      divide_reg  = 16'd1;
      divide_left = 16'd1;
      ticks       = '0;
      errors      = 0;
      releases_seen = 0;
      ticks_done  = 0;
      for (int i = 0; i < NumSlots; i++) begin
        slot_valid[i]  = 1'b0;
        slot_status[i] = ST_KILLED;
        slot_period[i] = '0;
        slot_offset[i] = '0;
      end
    endfunction

    function void set_divide(logic [15:0] v);
      divide_reg  = v;
      divide_left = v;
    endfunction

    // Apply one accepted transaction and queue the releases it causes
    function void note_op(logic [2:0] kind, logic [3:0] idx, logic [15:0] per,
                          logic [7:0] off);
      int      n;
      int      first;
      release_t r;
      n = 0;
      first = owed.size();
      if (kind == KIND_TIMER) begin
        if (divide_left > 16'd1) begin
          divide_left = divide_left - 16'd1;
          return;
        end
        divide_left = divide_reg;
        ticks = ticks + 32'd1;
        ticks_done++;
        for (int i = 0; i < NumSlots && n < OutLimit; i++) begin
          if (slot_valid[i] && slot_status[i] == ST_READY && slot_period[i] != 0 &&
              ticks >= {24'd0, slot_offset[i]} &&
              ((ticks - {24'd0, slot_offset[i]}) % {16'd0, slot_period[i]}) == 0) begin
            r.slot = i[3:0];
            r.last = 1'b0;
            r.tick = ticks;
            owed.push_back(r);
            n++;
          end
        end
        if (n > 0) owed[first + n - 1].last = 1'b1;
        return;
      end
      if (idx >= NumSlots) return;
      case (kind)
        KIND_CREATE: begin
          if (per != 0) begin
            slot_valid[idx]  = 1'b1;
            slot_status[idx] = ST_READY;
            slot_period[idx] = per;
            slot_offset[idx] = off;
          end
        end
        KIND_SUSPEND: slot_status[idx] = ST_PAUSED;
        KIND_RESUME: begin
          if (slot_status[idx] == ST_PAUSED) slot_status[idx] = ST_READY;
        end
        KIND_DELETE: begin
          slot_status[idx] = ST_KILLED;
          slot_valid[idx]  = 1'b0;
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    // Compare one accepted release with the oldest owed release
    task check_release(logic [3:0] slot, logic last, logic [31:0] tick);
      release_t e;
      releases_seen++;
      if (owed.size() == 0) begin
        report($sformatf("unexpected release slot %0d tick %0d", slot, tick));
        return;
      end
      e = owed.pop_front();
      if (slot !== e.slot)
        report($sformatf("due_task %0d, want %0d (tick %0d)", slot, e.slot, e.tick));
      if (last !== e.last)
        report($sformatf("last_due %0b, want %0b (tick %0d)", last, e.last, e.tick));
      if (tick !== e.tick)
        report($sformatf("tick_number %0d, want %0d", tick, e.tick));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_kind;
  logic [3:0]  in_task_index;
  logic [15:0] in_period;
  logic [7:0]  in_start_offset;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_due_task;
  logic        out_last_due;
  logic [31:0] out_tick_number;

  release_scoreboard sb;
  int unsigned idle_cycles;
  int unsigned stall_phase;

  periodic_task_release_scheduler_unit #(.NUM_TASKS(NumSlots)) dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_task_index(in_task_index), .in_period(in_period),
    .in_start_offset(in_start_offset), .out_valid(out_valid),
    .out_stall(out_stall), .out_due_task(out_due_task),
    .out_last_due(out_last_due), .out_tick_number(out_tick_number)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // Receiver stall: modes rotate between none, sparse and heavy
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    case ((stall_phase / 80) % 3)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // Check releases as they are taken
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_release(out_due_task, out_last_due, out_tick_number);
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no transaction for %0d cycles", IdleLimit);
      $display("status: fail");
      $finish;
    end
  end

  int unsigned burst_left;

  // Drive one operation and hold it until taken
  task send_op(logic [2:0] kind, logic [3:0] idx, logic [15:0] per, logic [7:0] off);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_task_index   <= idx;
    in_period       <= per;
    in_start_offset <= off;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_op(kind, idx, per, off);
    burst_left--;
  endtask

  // Let the block go quiet, then write the divider
  task write_divide(logic [15:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_divide(v);
  endtask

  task random_op();
    int unsigned pick;
    logic [15:0] per;
    pick = $urandom_range(0, 99);
    per  = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 6));
    if (pick < 55)
      send_op(KIND_TIMER, 4'($urandom), 16'($urandom), 8'($urandom));
    else if (pick < 75)
      send_op(KIND_CREATE,
              ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, 7)),
              per,
              ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12)));
    else if (pick < 84)
      send_op(KIND_SUSPEND, 4'($urandom_range(0, 9)), 16'($urandom), 8'($urandom));
    else if (pick < 93)
      send_op(KIND_RESUME, 4'($urandom_range(0, 9)), 16'($urandom), 8'($urandom));
    else if (pick < 97)
      send_op(KIND_DELETE, 4'($urandom_range(0, 9)), 16'($urandom), 8'($urandom));
    else
      send_op(3'($urandom_range(5, 7)), 4'($urandom), 16'($urandom), 8'($urandom));
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0; cfg_we = 1'b0; cfg_wdata = '0;
    in_valid = 1'b0; in_kind = KIND_TIMER; in_task_index = '0;
    in_period = '0; in_start_offset = '0;
    out_stall = 1'b0; stall_phase = 0; idle_cycles = 0; burst_left = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: table edits, extremes and the corner cases
    write_divide(16'd1);
    send_op(KIND_CREATE, 4'd0, 16'd1, 8'd0);
    send_op(KIND_CREATE, 4'd7, 16'hFFFF, 8'hFF);
    send_op(KIND_CREATE, 4'd3, 16'd0, 8'd0);       // zero period ignored
    send_op(KIND_CREATE, 4'd15, 16'd1, 8'd0);      // out of range ignored
    send_op(KIND_CREATE, 4'd8, 16'd1, 8'd0);
    send_op(KIND_CREATE, 4'd5, 16'd2, 8'd3);
    send_op(KIND_RESUME, 4'd5, 16'd0, 8'd0);       // resume on ready: no change
    send_op(KIND_SUSPEND, 4'd2, 16'd0, 8'd0);      // suspend an empty slot
    send_op(KIND_CREATE, 4'd2, 16'd1, 8'd1);       // create clears the pause
    for (int i = 1; i < NumSlots; i++)
      if (i != 2 && i != 5 && i != 7) send_op(KIND_CREATE, 4'(i), 16'd1, 8'd0);
    send_op(KIND_TIMER, 4'd0, 16'd0, 8'd0);        // all slots but 5 and 7 due at once
    send_op(KIND_SUSPEND, 4'd0, 16'd0, 8'd0);
    send_op(KIND_TIMER, 4'd0, 16'd0, 8'd0);
    send_op(KIND_RESUME, 4'd0, 16'd0, 8'd0);
    send_op(KIND_DELETE, 4'd1, 16'd0, 8'd0);
    send_op(3'd5, 4'd0, 16'd0, 8'd0);
    send_op(3'd7, 4'hF, 16'hFFFF, 8'hFF);
    send_op(KIND_TIMER, 4'd0, 16'd0, 8'd0);

    // Random phases over several dividers, extremes included
    write_divide(16'd3);
    repeat (70) random_op();
    write_divide(16'd0);
    repeat (70) random_op();
    write_divide(16'hFFFF);
    repeat (10) send_op(KIND_TIMER, 4'd0, 16'd0, 8'd0);
    write_divide(16'd2);
    repeat (60) random_op();
    write_divide(16'd1);
    repeat (70) random_op();

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (sb.owed.size() != 0) sb.report("releases left unseen at end of run");

    $display("covered %0d system ticks and %0d checked releases over five dividers",
             sb.ticks_done, sb.releases_seen);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
